FILE: hw/rtl/idmt_pkg.sv
// Package with the shared types, codes and helpers of the ID membership table.
`default_nettype none

package idmt_pkg;

  // Table geometry.
  localparam int SLOTS = 20;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W = 8;
  localparam int SLOT_W = 5;

  // Operation codes.
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Outcome codes.
  localparam logic [2:0] OUT_ABSENT   = 3'd0;
  localparam logic [2:0] OUT_PRESENT  = 3'd1;
  localparam logic [2:0] OUT_ADDED    = 3'd2;
  localparam logic [2:0] OUT_ALREADY  = 3'd3;
  localparam logic [2:0] OUT_FULL     = 3'd4;
  localparam logic [2:0] OUT_REMOVED  = 3'd5;
  localparam logic [2:0] OUT_NOTFOUND = 3'd6;

  typedef struct packed {
    logic [1:0]      func;
    logic [ID_W-1:0] peer_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        outcome;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

  // Access request from the sequencer to the slot store.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    logic [ID_W-1:0]  wr_data;
  } store_req_t;

  // Reported slot index: the low bits of the scan index.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/idmt_slot_store.sv
// Slot store of the ID membership table: one read and one write port at the scan index.
`default_nettype none

module idmt_slot_store
  import idmt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire store_req_t      req,
  output logic [ID_W-1:0]      rd_data
);

  logic [ID_W-1:0] slots [SLOTS];

  // All slots are empty after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (req.wr_en) begin
      slots[req.addr] <= req.wr_data;
    end
  end

  assign rd_data = slots[req.addr];

endmodule

`default_nettype wire

FILE: hw/rtl/idmt_scan_seq.sv
// Scan sequencer and shared compare unit of the ID membership table.
`default_nettype none

module idmt_scan_seq
  import idmt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire in_item_t        cmd,
  output logic                 busy,
  output logic                 done,
  output out_item_t            result,
  output store_req_t           req,
  input  wire logic [ID_W-1:0] rd_data
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0]       state;
  logic [0:0]       state_next;
  logic [IDX_W-1:0] idx;
  logic [1:0]       func;
  logic [ID_W-1:0]  peer_id;

  logic             finish;
  out_item_t        res_next;
  logic             hit_eq;
  logic             hit_empty;
  logic             last;

  // The shared compare unit looks at one slot per cycle.
  assign hit_eq    = (rd_data == peer_id);
  assign hit_empty = (rd_data == '0);
  assign last      = (idx == IDX_W'(SLOTS - 1));

  always_comb begin
    finish      = 1'b0;
    res_next    = '0;
    req.addr    = idx;
    req.wr_en   = 1'b0;
    req.wr_data = peer_id;
    state_next  = state;
    if (state == ST_SCAN) begin
      unique case (func)
        FUNC_ADD: begin
          if (hit_empty) begin
            req.wr_en = 1'b1;
            finish    = 1'b1;
            res_next  = '{outcome: OUT_ADDED, slot: to_slot(idx)};
          end else if (hit_eq) begin
            finish   = 1'b1;
            res_next = '{outcome: OUT_ALREADY, slot: to_slot(idx)};
          end else if (last) begin
            finish   = 1'b1;
            res_next = '{outcome: OUT_FULL, slot: '0};
          end
        end
        FUNC_REMOVE: begin
          if (hit_eq) begin
            req.wr_en   = 1'b1;
            req.wr_data = '0;
            finish      = 1'b1;
            res_next    = '{outcome: OUT_REMOVED, slot: to_slot(idx)};
          end else if (last) begin
            finish   = 1'b1;
            res_next = '{outcome: OUT_NOTFOUND, slot: '0};
          end
        end
        default: begin
          // Lookup, and the unused code that behaves as one.
          if (hit_eq) begin
            finish   = 1'b1;
            res_next = '{outcome: OUT_PRESENT, slot: to_slot(idx)};
          end else if (last) begin
            finish   = 1'b1;
            res_next = '{outcome: OUT_ABSENT, slot: '0};
          end
        end
      endcase
      if (finish) begin
        state_next = ST_IDLE;
      end
    end else if (start) begin
      state_next = ST_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      func    <= cmd.func;
      peer_id <= cmd.peer_id;
      idx     <= '0;
    end else if (state == ST_SCAN) begin
      idx <= idx + IDX_W'(1);
    end
    if (finish) begin
      result <= res_next;
    end
  end

  assign busy = (state == ST_SCAN);

endmodule

`default_nettype wire

FILE: hw/rtl/id_membership_table.sv
// Top level of the ID membership table: a small associative table of peer IDs.
`default_nettype none

// The table holds SLOTS peer IDs of 8 bits; a slot that holds zero is empty.
// A command beat is taken at a rising edge where start is high and busy is
// low. The command carries an operation (lookup, add or remove) and an ID.
// The sequencer then scans the slots from slot 0 upward, one slot per cycle,
// through a single shared compare unit, and busy stays high meanwhile.
// The scan ends at the first slot that settles the command, or after the
// last slot when none does. The result beat follows in the cycle
// after the scan ends, on result for exactly one cycle marked by done.
// The next command may be accepted in that same cycle; no new command is
// taken while a scan is still in progress.
// The receiver has no way to hold results off; each done beat is taken at
// the edge that ends its cycle. Synchronous reset empties every slot at
// once and returns the sequencer to idle with no result pending.
module id_membership_table
  import idmt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_item_t cmd,
  output logic          busy,
  output logic          done,
  output out_item_t     result
);

  store_req_t      req;
  logic [ID_W-1:0] rd_data;

  // Sequencer with the comparator; it drives the store's single address.
  idmt_scan_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .req     (req),
    .rd_data (rd_data)
  );

  // Slot registers, read and written at the scan index.
  idmt_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  // A result beat never overlaps a scan in progress.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while the scan is still busy");

  // An accepted command always starts a scan.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted command did not start a scan");

  // The table changes only during a scan.
  assert property (@(posedge clk) disable iff (rst) req.wr_en |-> busy)
    else $error("slot written outside a scan");

  // Outcomes that involve no slot report slot zero.
  assert property (@(posedge clk) disable iff (rst)
    (done && (result.outcome == OUT_ABSENT || result.outcome == OUT_FULL ||
              result.outcome == OUT_NOTFOUND)) |-> (result.slot == '0))
    else $error("miss outcome reported a nonzero slot");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the ID membership table, with scoreboard, driver and monitor.
`timescale 1ns / 1ps

module testbench
  import idmt_pkg::*;
();

  // The unused operation code behaves as a lookup, so it gets its own name here.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Tracks the slot contents the block should hold and the results it still owes.
  // Every accepted command beat is run through the same slot-by-slot scan the
  // block performs, and the outcome it implies is queued until done shows up.
  class id_table_tracker;
    logic [ID_W-1:0] ids[SLOTS];
    out_item_t       expected_outcomes[$];
    int              errors;

    function new();
      foreach (ids[k]) ids[k] = '0;
      errors = 0;
    endfunction

    // Applies one accepted command to the shadow table and queues its outcome.
    function void predict_command(input in_item_t c);
      out_item_t exp_item;
      bit        found;
      found = 0;
      exp_item.slot = '0;
      case (c.func)
        FUNC_ADD: begin
          exp_item.outcome = OUT_FULL;
          for (int k = 0; k < SLOTS; k++) begin
            if (!found && ids[k] == '0) begin
              ids[k] = c.peer_id;
              exp_item.outcome = OUT_ADDED;
              exp_item.slot = SLOT_W'(k);
              found = 1;
            end else if (!found && ids[k] == c.peer_id) begin
              exp_item.outcome = OUT_ALREADY;
              exp_item.slot = SLOT_W'(k);
              found = 1;
            end
          end
        end
        FUNC_REMOVE: begin
          exp_item.outcome = OUT_NOTFOUND;
          for (int k = 0; k < SLOTS; k++) begin
            if (!found && ids[k] == c.peer_id) begin
              ids[k] = '0;
              exp_item.outcome = OUT_REMOVED;
              exp_item.slot = SLOT_W'(k);
              found = 1;
            end
          end
        end
        default: begin
          // Lookup, and the spare code that decodes as a lookup.
          exp_item.outcome = OUT_ABSENT;
          for (int k = 0; k < SLOTS; k++) begin
            if (!found && ids[k] == c.peer_id) begin
              exp_item.outcome = OUT_PRESENT;
              exp_item.slot = SLOT_W'(k);
              found = 1;
            end
          end
        end
      endcase
      expected_outcomes.push_back(exp_item);
    endfunction

    // Compares one result beat with the oldest outcome still owed.
    function void check_outcome(input out_item_t got);
      out_item_t exp_item;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result beat with nothing expected, got outcome %0d slot %0d",
                 $time, got.outcome, got.slot);
        errors++;
        return;
      end
      exp_item = expected_outcomes.pop_front();
      if (got.outcome !== exp_item.outcome) begin
        $display("%0t: outcome mismatch, expected %0d, got %0d",
                 $time, exp_item.outcome, got.outcome);
        errors++;
      end
      if (got.slot !== exp_item.slot) begin
        $display("%0t: slot mismatch, expected %0d, got %0d",
                 $time, exp_item.slot, got.slot);
        errors++;
      end
    endfunction
  endclass

  // Clock and a reset that is held from time zero.
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  cmd = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  always #2 clk = ~clk;

  id_membership_table u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  id_table_tracker tracker;

  // A handful of IDs that the random commands keep returning to, so that adds
  // collide, removes hit and the table actually fills up and drains again.
  logic [ID_W-1:0] id_pool[24];

  // Monitor. Both handshakes are read at the rising edge, where busy, done and
  // result still hold the values the block saw at that edge. The result beat is
  // checked first; it always belongs to a command accepted at an earlier edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_outcome(result);
      if (start && !busy) tracker.predict_command(cmd);
    end
  end

  // Presents one command beat and returns at the edge where it is accepted.
  // Start is left high so that a following beat can go out back to back.
  task automatic send_command(input logic [1:0] func, input logic [ID_W-1:0] peer_id);
    start <= 1'b1;
    cmd <= '{func: func, peer_id: peer_id};
    do @(posedge clk); while (busy);
  endtask

  // Drops start and waits until every owed result has arrived. The first edge
  // lets the monitor record a beat accepted at the edge this task starts on.
  task automatic drain_outstanding();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // Replaces about half of the ID pool with fresh random values.
  task automatic refresh_pool();
    foreach (id_pool[k]) begin
      if ($urandom_range(0, 1) == 0) id_pool[k] = ID_W'($urandom);
    end
  endtask

  // Builds one random command. The mode leans the mix toward filling the table,
  // toward emptying it, or keeps it balanced.
  function automatic in_item_t random_command(input int mode);
    in_item_t c;
    int       roll;
    int       add_pct;
    int       rem_pct;
    case (mode)
      0:       begin add_pct = 65; rem_pct = 15; end
      1:       begin add_pct = 15; rem_pct = 65; end
      default: begin add_pct = 35; rem_pct = 35; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 5) c.func = FUNC_SPARE;
    else if (roll < 5 + add_pct) c.func = FUNC_ADD;
    else if (roll < 5 + add_pct + rem_pct) c.func = FUNC_REMOVE;
    else c.func = FUNC_LOOKUP;
    roll = $urandom_range(0, 99);
    if (roll < 80) c.peer_id = id_pool[$urandom_range(0, 23)];
    else if (roll < 85) c.peer_id = '0;
    else c.peer_id = ID_W'($urandom);
    return c;
  endfunction

  // One random phase: bursts of back-to-back beats of random length, with
  // random gaps between them. Some gaps are zero, which gives long stretches
  // where start never drops. The phase ends with start still high, so the
  // caller decides how to idle afterward.
  task automatic run_phase(input int count, input int mode);
    int       sent;
    int       burst;
    int       gap;
    in_item_t c;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        c = random_command(mode);
        send_command(c.func, c.peer_id);
        sent++;
      end
      if (sent < count) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          start <= 1'b0;
          cmd <= in_item_t'($urandom);
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    foreach (id_pool[k]) id_pool[k] = ID_W'($urandom);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. An ID of zero matches an empty slot, so on an empty
    // table a lookup of zero reports present at slot 0 and a remove of zero
    // "removes" it without changing anything.
    send_command(FUNC_LOOKUP, 8'h00);
    send_command(FUNC_REMOVE, 8'h00);
    // Fill every slot with distinct nonzero IDs, the first being all ones.
    for (int k = 0; k < SLOTS; k++) send_command(FUNC_ADD, 8'hFF - ID_W'(k * 12));
    // The table is full now: a new ID is refused, a known one reports its slot.
    send_command(FUNC_ADD, 8'h77);
    send_command(FUNC_ADD, 8'hFF);
    // The spare operation code acts as a lookup; the last slot holds 8'h1B.
    send_command(FUNC_SPARE, 8'h1B);
    send_command(FUNC_REMOVE, 8'h1B);
    // With one empty slot at the top, zero is found there.
    send_command(FUNC_LOOKUP, 8'h00);
    send_command(FUNC_REMOVE, 8'h01);
    send_command(FUNC_LOOKUP, 8'h01);
    // Adding zero claims the empty slot, which still reads as empty after.
    send_command(FUNC_ADD, 8'h00);
    send_command(FUNC_ADD, 8'h00);

    // Let everything settle before the random part starts.
    drain_outstanding();

    // Random part: nine phases with a random lean each, draining the block
    // completely between phases so that idle also follows a quiet stretch.
    for (int p = 0; p < 9; p++) begin
      if (p % 3 == 0) refresh_pool();
      run_phase(100, $urandom_range(0, 2));
      drain_outstanding();
    end

    // Nothing is owed any more; give a stray late beat a chance to show up.
    repeat (SLOTS + 4) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, even with every scan taking
  // the full table and the widest gaps between beats.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
